// File: design/chvl_pkg.sv
// types and constants shared by the cookie header value lookup
package chvl_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;

    localparam int NAME_BYTES = 16;

    // register indexes, address bits [4:3]
    localparam logic [1:0] REG_NAME_LENGTH = 2'd0;
    localparam logic [1:0] REG_NAME_LOW    = 2'd1;
    localparam logic [1:0] REG_NAME_HIGH   = 2'd2;

    typedef enum logic [4:0] {
        PH_SKIP     = 5'b00001,
        PH_KEY      = 5'b00010,
        PH_VAL_OUT  = 5'b00100,
        PH_VAL_SKIP = 5'b01000,
        PH_AFTER    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       found;
        logic       done_res;
        logic       value_valid;
        logic [7:0] value_byte;
    } result_t;

endpackage

// File: design/cookie_header_value_lookup.sv
// a result is registered onto m_, passing through the skid entry while m_ is stalled
// throughput: one header byte per cycle while s_tready is high; no-result bytes leave nothing behind
// a two-entry output stage (register plus skid) keeps s_tready registered
// s_tready drops only while both output entries hold results
// reset: synchronous active-low aresetn clears scan state, output stage and registers
module cookie_header_value_lookup
    import chvl_pkg::*;
#(
    parameter int NAME_MAX = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] header_byte
    input  logic        s_tlast,   // is_last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] value_byte
    output logic [1:0]  m_tuser,   // [0] value_valid, [1] found
    output logic        m_tlast,   // done_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int KW = $clog2(NAME_MAX + 2);
    localparam logic [KW-1:0] KEY_SAT = KW'(NAME_MAX + 1);
    localparam logic [4:0] NAME_LIM = 5'(NAME_MAX);

    // configuration registers
    logic [4:0]  name_length_reg;
    logic [63:0] name_low_reg;
    logic [63:0] name_high_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_length_reg <= '0;
            name_low_reg    <= '0;
            name_high_reg   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
                REG_NAME_LENGTH: name_length_reg <= pwdata[4:0];
                REG_NAME_LOW:    name_low_reg    <= pwdata;
                REG_NAME_HIGH:   name_high_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_NAME_LENGTH: prdata = {59'd0, name_length_reg};
            REG_NAME_LOW:    prdata = name_low_reg;
            REG_NAME_HIGH:   prdata = name_high_reg;
            default:         prdata = '0;
        endcase
    end

    // scan state
    phase_t        phase_reg, phase_next;
    logic [KW-1:0] key_count_reg, key_count_next;
    logic          key_match_reg, key_match_next;
    logic          match_seen_reg, match_seen_next;

    logic          s_fire;
    logic          is_sep;
    logic          emit;
    logic [KW-1:0] base_count;
    logic          base_match;
    logic [4:0]    base_count5;
    logic [4:0]    cur_count5;
    logic [127:0]  name_all;
    logic [7:0]    name_byte;
    logic [KW-1:0] absorb_count;
    logic          absorb_match;
    logic          hit;
    result_t       res_new;

    assign s_fire   = s_tvalid && s_tready;
    assign is_sep   = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) || (s_tdata == CH_SEMI);
    assign name_all = {name_high_reg, name_low_reg};

    // a key byte in the skip phase starts a fresh key
    assign base_count  = (phase_reg == PH_SKIP) ? '0 : key_count_reg;
    assign base_match  = (phase_reg == PH_SKIP) ? 1'b1 : key_match_reg;
    assign base_count5 = 5'(base_count);
    assign name_byte   = name_all[{base_count5[3:0], 3'b000} +: 8];

    always_comb begin
        absorb_match = base_match;
        if (base_count5 < name_length_reg && base_count5 < NAME_LIM) begin
            if (name_byte != s_tdata) begin
                absorb_match = 1'b0;
            end
        end else begin
            absorb_match = 1'b0;
        end
        absorb_count = (base_count < KEY_SAT) ? base_count + 1'b1 : base_count;
    end

    assign cur_count5 = 5'(key_count_reg);
    assign hit = key_match_reg && (cur_count5 == name_length_reg) &&
                 (name_length_reg != 5'd0) && (name_length_reg <= NAME_LIM);

    always_comb begin
        phase_next      = phase_reg;
        key_count_next  = key_count_reg;
        key_match_next  = key_match_reg;
        match_seen_next = match_seen_reg;
        emit            = 1'b0;
        case (phase_reg)
            PH_SKIP, PH_KEY: begin
                if (phase_reg == PH_KEY && s_tdata == CH_SEMI) begin
                    phase_next     = PH_SKIP;
                    key_count_next = '0;
                    key_match_next = 1'b1;
                end else if (phase_reg == PH_SKIP && is_sep) begin
                    phase_next = PH_SKIP;
                end else if (s_tdata == CH_EQ) begin
                    // end of key: in skip phase the key is empty and cannot hit
                    phase_next     = hit ? PH_VAL_OUT : PH_VAL_SKIP;
                    match_seen_next = match_seen_reg || hit;
                    key_count_next = '0;
                    key_match_next = 1'b1;
                end else begin
                    phase_next     = PH_KEY;
                    key_count_next = absorb_count;
                    key_match_next = absorb_match;
                end
            end
            PH_VAL_OUT: begin
                if (s_tdata == CH_SEMI) begin
                    phase_next = PH_AFTER;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_VAL_SKIP: begin
                if (s_tdata == CH_SEMI) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_AFTER: begin
                phase_next = PH_AFTER;
            end
            default: begin
                phase_next = PH_SKIP;
            end
        endcase
    end

    always_comb begin
        res_new.value_byte  = emit ? s_tdata : 8'd0;
        res_new.value_valid = emit;
        res_new.done_res    = s_tlast;
        res_new.found       = s_tlast && match_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SKIP;
            key_count_reg  <= '0;
            key_match_reg  <= 1'b1;
            match_seen_reg <= 1'b0;
        end else if (s_fire) begin
            if (s_tlast) begin
                phase_reg      <= PH_SKIP;
                key_count_reg  <= '0;
                key_match_reg  <= 1'b1;
                match_seen_reg <= 1'b0;
            end else begin
                phase_reg      <= phase_next;
                key_count_reg  <= key_count_next;
                key_match_reg  <= key_match_next;
                match_seen_reg <= match_seen_next;
            end
        end
    end

    // output register with skid entry
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    push;
    logic    m_fire;

    assign push     = s_fire && (emit || s_tlast);
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !m_fire) begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !m_fire) begin
                skid_reg <= res_new;
            end else begin
                out_reg <= res_new;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.value_byte;
    assign m_tuser[0] = out_reg.value_valid;
    assign m_tuser[1] = out_reg.found;
    assign m_tlast    = out_reg.done_res;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_found_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("found flag outside a done item");

    a_key_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= KEY_SAT)
        else $error("key count beyond saturation");

    a_last_clears_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (phase_reg == PH_SKIP && !match_seen_reg))
        else $error("scan state not cleared after last item");
`endif

endmodule
